### design/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg
// Shared types and constants for the spatiotemporal median denoiser.
// ----------------------------------------------------------------------------
package smd_pkg;

  localparam int MAX_LINE_BYTES_DEF = 4096;
  localparam int MAX_STRIDE_DEF     = 4;
  localparam int WIN_MAX            = 11;

  localparam logic [1:0] CFG_LINE_BYTES = 2'd0;
  localparam logic [1:0] CFG_BPP        = 2'd1;
  localparam logic [1:0] CFG_BAND_ROWS  = 2'd2;

  typedef struct packed {
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] bot;
    logic [8:0] pv;
    logic [8:0] nv;
  } colv_t;

  typedef enum logic [1:0] {
    ST_IN,
    ST_RD,
    ST_EMIT
  } state_t;

  // one result request for the median unit
  typedef struct packed {
    logic [3:0] d;
    logic       use_left;
    logic       use_right;
    logic       top;
    logic       bot;
    logic       last;
  } req_t;

endpackage

### design/smd_median.sv
// ----------------------------------------------------------------------------
// smd_median
// Registered window gather and rank select over up to eleven bytes.
// ----------------------------------------------------------------------------
module smd_median import smd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [7:0]      vals [WIN_MAX],
  input  logic [WIN_MAX-1:0] vld,
  output logic            done,
  output logic [7:0]      result
);

  logic [7:0]         v_r [WIN_MAX];
  logic [WIN_MAX-1:0] m_r;
  logic               s_r;
  logic               done_r;
  logic [7:0]         res_r;
  logic [3:0]         n_w;
  logic [7:0]         sel_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r    <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s_r    <= start;
      done_r <= s_r;
    end
    if (start) begin
      v_r <= vals;
      m_r <= vld;
    end
    if (s_r) res_r <= sel_w;
  end

  // element e is the pick when (#less) <= k < (#less + #equal-before-or-self)
  always_comb begin
    logic [3:0] lt, le;
    n_w   = 4'(($countones(m_r)));
    sel_w = 8'd0;
    for (int e = 0; e < WIN_MAX; e++) begin
      lt = '0;
      le = '0;
      for (int f = 0; f < WIN_MAX; f++) begin
        if (m_r[f] && (v_r[f] < v_r[e])) lt = lt + 4'd1;
        if (m_r[f] && (v_r[f] == v_r[e]) && (f <= e)) le = le + 4'd1;
      end
      if (m_r[e] && (lt + le > (n_w >> 1)) && (lt <= (n_w >> 1))) sel_w = v_r[e];
    end
  end

  assign done   = done_r;
  assign result = res_r;

  a_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(s_r))
    else $error("median done without start");

  a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    s_r |=> done_r)
    else $error("median start without done");

  a_start_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !s_r)
    else $error("median start while computing");

endmodule

### design/spatiotemporal_median_denoise.sv
// ----------------------------------------------------------------------------
// spatiotemporal_median_denoise
// 3x3 same-channel spatial plus temporal median over a raster band.
// ----------------------------------------------------------------------------
// channel | dir | fields
// in_     | in  | tdata: pixel, prev_pixel, next_pixel, has_prev, has_next; tuser: flush
// out_    | out | tdata: filtered; tlast: last
// cfg_    | in  | index 0 line_bytes, 1 bytes_per_pixel, 2 band_rows
// Steps: an item is accepted with a store read, then written back; if no result
// is due the input reopens, otherwise each result goes through start, rank,
// result and output word, skipped column offsets are stepped over, and the input then reopens.
// A line end emits up to five results.
// Line stores are single-port synchronous RAMs, read then written per item.
// Reset clears counters and the window register; stores hold garbage.
// A stalled output holds the unit; input waits until the item is done.
module spatiotemporal_median_denoise import smd_pkg::*; #(
  parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF,
  parameter int MAX_STRIDE     = MAX_STRIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pixel, prev_pixel, next_pixel, has_prev, has_next
  input  logic        in_tuser,   // flush
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // filtered
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int AW   = $clog2(MAX_LINE_BYTES);
  localparam int HIST = 2 * MAX_STRIDE + 1;

  logic [12:0] line_bytes_r, band_rows_r;
  logic [2:0]  bpp_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bytes_r <= 13'd1024;
      bpp_r        <= 3'd1;
      band_rows_r  <= 13'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_BYTES: line_bytes_r <= cfg_data;
        CFG_BPP:        bpp_r        <= cfg_data[2:0];
        CFG_BAND_ROWS:  band_rows_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [AW:0]  eff_l;
  logic [2:0]   eff_s;
  logic [12:0]  eff_b;
  always_comb begin
    eff_l = (line_bytes_r == 13'd0) ? (AW+1)'(1) :
            ({1'b0, line_bytes_r} > 14'(MAX_LINE_BYTES)) ? (AW+1)'(MAX_LINE_BYTES)
            : (AW+1)'(line_bytes_r);
    eff_s = (bpp_r == 3'd0) ? 3'd1 : (bpp_r > 3'(MAX_STRIDE)) ? 3'(MAX_STRIDE) : bpp_r;
    eff_b = (band_rows_r == 13'd0) ? 13'd1 : band_rows_r;
  end

  // line stores
  logic [7:0] older_mem [MAX_LINE_BYTES];
  logic [7:0] mid_mem   [MAX_LINE_BYTES];
  logic [8:0] pv_mem    [MAX_LINE_BYTES];
  logic [8:0] nv_mem    [MAX_LINE_BYTES];
  logic [7:0] older_q, mid_q;
  logic [8:0] pv_q, nv_q;

  state_t       state_r, state_nxt;
  logic [AW-1:0] col_r, c_r;
  logic [12:0]  row_r;
  logic [31:0]  item_r;
  logic         fl_r, le_r, top_r;
  colv_t        win_r [HIST];
  logic [3:0]   d_r, lo_r;
  logic         busy_r;
  logic [7:0]   hold_r;
  logic         hvld_r, hlast_r, last_pend_r;

  logic acc, fl_w;
  assign in_tready = (state_r == ST_IN);
  assign acc  = in_tvalid && in_tready;
  assign fl_w = in_tuser || (row_r >= eff_b);

  logic [AW-1:0] c_w;
  assign c_w = ({1'b0, col_r} < eff_l - 1'b1) ? col_r : AW'(eff_l - 1'b1);

  logic rd_en, wr_en;
  assign rd_en = acc && !(fl_w && row_r == 13'd0);
  assign wr_en = (state_r == ST_RD);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      older_q <= older_mem[c_w];
      mid_q   <= mid_mem[c_w];
      pv_q    <= pv_mem[c_w];
      nv_q    <= nv_mem[c_w];
    end
    if (wr_en) begin
      older_mem[c_r] <= mid_q;
      mid_mem[c_r]   <= item_r[7:0];
      pv_mem[c_r]    <= {item_r[24], item_r[15:8]};
      nv_mem[c_r]    <= {item_r[25], item_r[23:16]};
    end
  end

  // pending request: column offset d walks from S down to lo
  logic        go;
  logic [7:0]  mv [WIN_MAX];
  logic [WIN_MAX-1:0] mk;
  logic        mdone;
  logic [7:0]  mres;
  logic        top_w, bot_w, ul, ur;
  logic [3:0]  ds;
  logic        emit_ok, last_req;

  assign ds      = {1'b0, eff_s};
  assign emit_ok = ({1'b0, d_r} <= 5'(c_r)) || (AW > 4 && c_r >= AW'(16));
  assign top_w   = top_r;
  assign bot_w   = !fl_r;
  assign ul      = (c_r - AW'(d_r)) >= AW'(ds);
  assign ur      = d_r >= ds;
  assign last_req = (d_r == lo_r) || ({1'b0, d_r - 4'd1} > 5'(c_r) && c_r < AW'(16));

  always_comb begin
    colv_t l, m, r;
    l = win_r[d_r + ds];
    m = win_r[d_r];
    r = win_r[d_r - ds];
    mk = '0;
    mv[0] = l.top; mv[1] = l.mid; mv[2] = l.bot;
    mv[3] = m.top; mv[4] = m.mid; mv[5] = m.bot;
    mv[6] = r.top; mv[7] = r.mid; mv[8] = r.bot;
    mv[9] = m.pv[7:0]; mv[10] = m.nv[7:0];
    mk[0] = ul && top_w; mk[1] = ul; mk[2] = ul && bot_w;
    mk[3] = top_w; mk[4] = 1'b1; mk[5] = bot_w;
    mk[6] = ur && top_w; mk[7] = ur; mk[8] = ur && bot_w;
    mk[9] = m.pv[8]; mk[10] = m.nv[8];
  end

  assign go = (state_r == ST_EMIT) && !busy_r && !hvld_r && !last_pend_r && emit_ok;

  smd_median u_med (
    .clk(clk), .rst_n(rst_n), .start(go), .vals(mv), .vld(mk),
    .done(mdone), .result(mres)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IN:   if (rd_en) state_nxt = ST_RD;
      ST_RD:   state_nxt = (row_r >= 13'd1) ? ST_EMIT : ST_IN;
      ST_EMIT: begin
        if (!busy_r && !hvld_r && (!emit_ok || last_req) && (go || !emit_ok))
          state_nxt = ST_EMIT;
        if (!busy_r && !hvld_r && last_pend_r) state_nxt = ST_IN;
      end
      default: state_nxt = ST_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IN;
      col_r   <= '0;
      row_r   <= '0;
      busy_r  <= 1'b0;
      hvld_r  <= 1'b0;
      last_pend_r <= 1'b0;
      for (int i = 0; i < HIST; i++) win_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (rd_en) begin
        item_r <= in_tdata;
        fl_r   <= fl_w;
        top_r  <= (row_r >= 13'd2);
        c_r    <= c_w;
        le_r   <= ({1'b0, c_w} == eff_l - 1'b1);
        d_r    <= ds;
        lo_r   <= ({1'b0, c_w} == eff_l - 1'b1) ? 4'd0 : ds;
        last_pend_r <= 1'b0;
      end
      if (state_r == ST_RD) begin
        for (int i = HIST - 1; i > 0; i--) win_r[i] <= win_r[i-1];
        win_r[0] <= '{top: older_q, mid: mid_q, bot: item_r[7:0],
                      pv: pv_q, nv: nv_q};
        if (le_r) begin
          col_r <= '0;
          row_r <= fl_r ? 13'd0 : row_r + 13'd1;
        end else begin
          col_r <= c_r + 1'b1;
        end
      end
      if (state_r == ST_EMIT && !busy_r && !hvld_r && !last_pend_r) begin
        if (d_r == lo_r) last_pend_r <= 1'b1;
        else d_r <= d_r - 4'd1;
        if (go) begin
          busy_r  <= 1'b1;
          hlast_r <= last_req;
        end
      end
      if (mdone) begin
        busy_r <= 1'b0;
        hvld_r <= 1'b1;
        hold_r <= mres;
      end else if (hvld_r && out_tready) begin
        hvld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = hvld_r;
  assign out_tdata  = hold_r;
  assign out_tlast  = hlast_r;

  a_hold_vs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(hvld_r && busy_r))
    else $error("result and unit busy together");

  a_input_closed: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && (busy_r || hvld_r)))
    else $error("input open while emitting");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(mdone && hvld_r))
    else $error("result overrun");

endmodule
